@@ src/aswdb_pkg.sv @@
// Shared types, codes and reset values for the analog switch debounce block.
package aswdb_pkg;

    localparam int unsigned SampleW  = 16;
    localparam int unsigned LevelW   = 10;
    localparam int unsigned CountW   = 8;
    localparam int unsigned PeriodW  = 10;
    localparam int unsigned LimitW   = 24;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 24;

    localparam logic [SampleW-1:0] AdcMaxValid = 16'h03FF;

    typedef enum logic [1:0] {
        ST_UNKNOWN  = 2'd0,
        ST_RELEASED = 2'd1,
        ST_PRESSED  = 2'd2
    } t_sw_state;

    typedef enum logic [2:0] {
        EV_NONE           = 3'd0,
        EV_OFF_TO_ON      = 3'd1,
        EV_ON_TO_OFF      = 3'd2,
        EV_STUCK_PRESSED  = 3'd3,
        EV_STUCK_RELEASED = 3'd4
    } t_event;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PRESS_THRESHOLD   = 3'd0,
        CFG_RELEASE_THRESHOLD = 3'd1,
        CFG_DEBOUNCE_SAMPLES  = 3'd2,
        CFG_SAMPLE_PERIOD_MS  = 3'd3,
        CFG_STUCK_LIMIT_MS    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LevelW-1:0]  press_threshold;
        logic [LevelW-1:0]  release_threshold;
        logic [CountW-1:0]  debounce_samples;
        logic [PeriodW-1:0] sample_period_ms;
        logic [LimitW-1:0]  stuck_limit_ms;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        press_threshold:   10'd300,
        release_threshold: 10'd10,
        debounce_samples:  8'd5,
        sample_period_ms:  10'd10,
        stuck_limit_ms:    24'd300000
    };

    typedef struct packed {
        t_sw_state          debounced;
        logic [CountW-1:0]  change_count;
        logic [TimeW-1:0]   dwell_ms;
        logic               stuck_mark;
    } t_state;

    localparam t_state StateReset = '{
        debounced:     ST_UNKNOWN,
        change_count:  '0,
        dwell_ms:      '0,
        stuck_mark:    1'b0
    };

    typedef struct packed {
        t_sw_state switch_state;
        logic      stuck;
        t_event    event_res;
    } t_result;

endpackage

@@ src/analog_switch_debounce_stuck_detect.sv @@
// Top level of the analog switch debouncer with hysteresis and stuck detection.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  sample   | i_in_valid / o_in_ready    | i_adc_sample[15:0]
//  result   | o_out_valid / i_out_ready  | o_switch_state[1:0], o_stuck, o_event_res[2:0]
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index[2:0], i_cfg_data[23:0]
//
// Each sample yields exactly one result. The sample waits in the input
// register while the update logic works on it; it then moves into the result
// register, from which the result transfers. A new sample is taken every
// cycle while the result is not stalled; the rate is set by the combinational
// state update (add, saturate, compare to the limit).
// Reset (i_rst_n low at a clock edge) loads the register defaults and clears
// the debounce state. A stalled result holds the pipe; the input register
// still frees up whenever the result register drains in the same cycle.
module analog_switch_debounce_stuck_detect (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [aswdb_pkg::SampleW-1:0]    i_adc_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_switch_state,
    output logic                             o_stuck,
    output logic [2:0]                       o_event_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [aswdb_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [aswdb_pkg::CfgDataW-1:0]   i_cfg_data
);
    import aswdb_pkg::*;

    t_cfg                r_cfg;
    t_state              r_state;
    t_state              n_state;
    t_result             r_result;
    t_result             n_result;
    logic                r_in_valid;
    logic [SampleW-1:0]  r_sample;
    logic                r_out_valid;
    logic                advance;

    // Move the held sample forward when the result slot is free or draining.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    // Writes should land only while idle; the block itself does not enforce this and takes them at once.
    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRESS_THRESHOLD:   r_cfg.press_threshold   <= i_cfg_data[LevelW-1:0];
                CFG_RELEASE_THRESHOLD: r_cfg.release_threshold <= i_cfg_data[LevelW-1:0];
                CFG_DEBOUNCE_SAMPLES:  r_cfg.debounce_samples  <= i_cfg_data[CountW-1:0];
                CFG_SAMPLE_PERIOD_MS:  r_cfg.sample_period_ms  <= i_cfg_data[PeriodW-1:0];
                CFG_STUCK_LIMIT_MS:    r_cfg.stuck_limit_ms    <= i_cfg_data[LimitW-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the sample until it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample <= i_adc_sample;
        end
    end

    aswdb_update u_update (
        .i_sample (r_sample),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Commit the debounce state only as the sample moves into the result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateReset;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_switch_state = r_result.switch_state;
    assign o_stuck        = r_result.stuck;
    assign o_event_res    = r_result.event_res;

endmodule

@@ src/aswdb_update.sv @@
// Per-sample next-state and result logic of the switch debouncer.
module aswdb_update (
    input  logic [aswdb_pkg::SampleW-1:0] i_sample,
    input  aswdb_pkg::t_cfg               i_cfg,
    input  aswdb_pkg::t_state             i_state,
    output aswdb_pkg::t_state             o_state,
    output aswdb_pkg::t_result            o_result
);
    import aswdb_pkg::*;

    logic [LevelW-1:0]  level;
    t_sw_state          cls;
    logic [TimeW:0]     time_sum;
    logic [CountW-1:0]  count_inc;
    t_state             upd;
    t_event             edge_ev;

    // Fold out-of-range samples to zero.
    assign level = (i_sample > AdcMaxValid) ? '0 : i_sample[LevelW-1:0];

    // Pressed test wins when the thresholds overlap.
    always_comb begin
        priority if (level >= i_cfg.press_threshold) begin
            cls = ST_PRESSED;
        end else if (level <= i_cfg.release_threshold) begin
            cls = ST_RELEASED;
        end else begin
            cls = ST_UNKNOWN;
        end
    end

    assign time_sum  = {1'b0, i_state.dwell_ms}
                     + {{(TimeW + 1 - PeriodW){1'b0}}, i_cfg.sample_period_ms};
    assign count_inc = (i_state.change_count < i_cfg.debounce_samples)
                     ? i_state.change_count + CountW'(1) : i_state.change_count;

    always_comb begin
        upd     = i_state;
        edge_ev = EV_NONE;
        if (cls != ST_UNKNOWN) begin
            if (cls == i_state.debounced) begin
                upd.change_count  = '0;
                // Saturate on carry out.
                upd.dwell_ms = time_sum[TimeW] ? '1 : time_sum[TimeW-1:0];
            end else begin
                upd.dwell_ms = '0;
                upd.change_count  = count_inc;
                if (count_inc >= i_cfg.debounce_samples) begin
                    upd.debounced    = cls;
                    upd.change_count = '0;
                    upd.stuck_mark   = 1'b0;
                    if (i_state.debounced == ST_RELEASED && cls == ST_PRESSED) begin
                        edge_ev = EV_OFF_TO_ON;
                    end else if (i_state.debounced == ST_PRESSED && cls == ST_RELEASED) begin
                        edge_ev = EV_ON_TO_OFF;
                    end
                end
            end
        end
    end

    // Stuck check runs on every sample and overrides an edge event.
    always_comb begin
        o_state             = upd;
        o_result.event_res  = edge_ev;
        if (!upd.stuck_mark
            && upd.dwell_ms >= {{(TimeW - LimitW){1'b0}}, i_cfg.stuck_limit_ms}) begin
            o_state.stuck_mark = 1'b1;
            o_result.event_res = (upd.debounced == ST_PRESSED)
                               ? EV_STUCK_PRESSED : EV_STUCK_RELEASED;
        end
        o_result.switch_state = o_state.debounced;
        o_result.stuck        = o_state.stuck_mark;
    end

endmodule

@@ src/aswdb_checker.sv @@
// Port-level checks for the analog switch debouncer, bound to the top level.
module aswdb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [1:0]                     o_switch_state,
    input logic                           o_stuck,
    input logic [2:0]                     o_event_res
);
    import aswdb_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_switch_state)
            && $stable(o_stuck) && $stable(o_event_res))
        else $error("result changed while stalled");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

    // A stuck event always comes with the stuck flag set.
    a_stuck_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_STUCK_PRESSED
            || o_event_res == EV_STUCK_RELEASED) |-> o_stuck)
        else $error("stuck event without stuck flag");

    // Edge events match the state they land in.
    a_edge_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_OFF_TO_ON || o_event_res == EV_STUCK_PRESSED)
            |-> o_switch_state == ST_PRESSED)
        else $error("press event with wrong state");

    a_release_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res == EV_ON_TO_OFF |-> o_switch_state == ST_RELEASED
            && !o_stuck)
        else $error("release event with wrong state");

endmodule

bind analog_switch_debounce_stuck_detect aswdb_checker u_aswdb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_switch_state (o_switch_state),
    .o_stuck        (o_stuck),
    .o_event_res    (o_event_res)
);
